@@ rtl/lottery_process_scheduler_macros.svh @@
// assertion helpers for the lottery scheduler
`ifndef LOTTERY_PROCESS_SCHEDULER_MACROS_SVH
`define LOTTERY_PROCESS_SCHEDULER_MACROS_SVH

// implication checked on every clock, off during reset
`define LPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lottery scheduler check failed");

// next-cycle implication checked on every clock, off during reset
`define LPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lottery scheduler check failed");

`endif

@@ rtl/lps_pkg.sv @@
`default_nettype none
package lps_pkg;
    localparam int MaxProcesses = 16;
    localparam int NumProcessorsReset = 1;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_RAN    = 2'd1,
        ST_IDLE   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV,
        S_PICK_RD,
        S_PICK_ACC,
        S_SEL_RD,
        S_SEL_WAIT,
        S_UPDATE,
        S_REPORT
    } state_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;
endpackage
`default_nettype wire

@@ rtl/lottery_process_scheduler.sv @@
`default_nettype none
// Lottery scheduler. A load (command 0) goes from start through the report state to its result
// strobe. A scheduling round (command 1) scans the process table in its memory at most twice,
// one entry per cycle, and runs a 31-step remainder unit in between. busy stays high until the
// result strobe; results appear for one cycle on done and cannot be held off, so the receiver
// must take them then.
module lottery_process_scheduler
    import lps_pkg::*;
#(
    parameter int MAX_PROCESSES = MaxProcesses
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [15:0] process_id,
    input  wire logic [15:0] tickets,
    input  wire logic [19:0] arrival_time,
    input  wire logic [15:0] burst_time,
    input  wire logic [30:0] random_value,
    output logic             done,
    output logic [1:0]       status,
    output logic [3:0]       slot,
    output logic [15:0]      chosen_id,
    output logic [3:0]       processor,
    output logic             finished,
    output logic [31:0]      completion_time,
    output logic [31:0]      turnaround,
    output logic [31:0]      waiting,
    output logic [31:0]      response,
    output logic [31:0]      time_now,
    output logic             all_done
);
    localparam int AW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    // entry word: id, tickets, arrival, burst, remaining, response, started, done
    localparam int EW = 16 + 16 + 20 + 16 + 16 + 32 + 1 + 1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] tk;
        logic [19:0] arr;
        logic [15:0] burst;
        logic [15:0] rem;
        logic [31:0] resp;
        logic        started;
        logic        fin;
    } entry_t;

    state_t state_reg, state_next;
    logic [4:0]    nproc_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] active_reg, active_next;
    logic [31:0]   time_reg, time_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   total_reg, total_next;
    logic [31:0]   win_reg, win_next;
    logic [30:0]   rand_reg;
    logic          cmd_reg;
    logic          found_reg, found_next;
    logic [AW-1:0] sel_reg, sel_next;
    entry_t        upd_reg, upd_next;
    logic          wb_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    logic          div_start_reg, div_done;
    logic [31:0]   div_rem;

    logic [1:0]  status_reg;
    logic [3:0]  slot_reg, proc_reg;
    logic [15:0] chosen_reg;
    logic        fin_reg, done_reg;
    logic [31:0] comp_reg, tat_reg, wait_reg, resp_reg;

    logic        apb_wr;
    logic [4:0]  np_eff;
    logic        eligible;
    logic [31:0] sum_add;
    logic [31:0] time_inc;
    logic        row_valid;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;
    assign prdata = (paddr == 2'd0) ? {27'd0, nproc_reg} : 32'd0;
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nproc_reg <= 5'(NumProcessorsReset);
        end
        else if (apb_wr && paddr == 2'd0)
        begin
            nproc_reg <= pwdata[4:0];
        end
    end

    assign np_eff   = (nproc_reg == 5'd0) ? 5'd1 : (nproc_reg > 5'd16 ? 5'd16 : nproc_reg);
    assign time_inc = (time_reg == 32'hFFFF_FFFF) ? time_reg : time_reg + 32'd1;

    // slot index mod processor count by compare and subtract of shifted divisors
    function automatic logic [3:0] proc_of(input logic [AW-1:0] s, input logic [4:0] np);
        logic [AW+4:0] r;
        r = (AW+5)'(s);
        for (int b = AW - 1; b >= 0; b--)
        begin
            if (r >= ((AW+5)'(np) << b))
            begin
                r = r - ((AW+5)'(np) << b);
            end
        end
        return r[3:0];
    endfunction

    lps_ram #(.WIDTH(EW), .DEPTH(MAX_PROCESSES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lps_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (rand_reg),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign eligible  = !ram_rdata.fin && ({12'd0, ram_rdata.arr} <= time_reg);
    assign sum_add   = eligible ? {16'd0, ram_rdata.tk} : 32'd0;
    assign row_valid = (idx_reg < count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (command == CMD_LOAD) ? S_REPORT : S_SUM_RD;
                end
            end
            S_SUM_RD:   state_next = (count_reg == '0) ? S_REPORT : S_SUM_ACC;
            S_SUM_ACC:
            begin
                if (idx_reg + CW'(1) >= count_reg)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (total_reg == 32'd0)
                begin
                    state_next = S_REPORT;
                end
                else if (div_done)
                begin
                    state_next = S_PICK_RD;
                end
            end
            S_PICK_RD:  state_next = S_PICK_ACC;
            S_PICK_ACC:
            begin
                if (found_next || idx_reg + CW'(1) >= count_reg)
                begin
                    state_next = found_next ? S_SEL_RD : S_REPORT;
                end
            end
            S_SEL_RD:   state_next = S_SEL_WAIT;
            S_SEL_WAIT: state_next = S_UPDATE;
            S_UPDATE:   state_next = S_REPORT;
            S_REPORT:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_raddr = idx_reg[AW-1:0];
        if (state_reg == S_PICK_ACC || state_reg == S_SUM_ACC)
        begin
            ram_raddr = AW'(idx_reg + CW'(1));
        end
        if (state_reg == S_SEL_RD || state_reg == S_SEL_WAIT)
        begin
            ram_raddr = sel_reg;
        end
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = upd_reg;
        if (state_reg == S_IDLE && start && command == CMD_LOAD && count_reg != CW'(MAX_PROCESSES))
        begin
            ram_we    = 1'b1;
            ram_wdata = '{id: process_id, tk: tickets, arr: arrival_time, burst: burst_time,
                          rem: burst_time, resp: 32'd0, started: 1'b0, fin: 1'b0};
        end
        if (wb_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = sel_reg;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        active_next = active_reg;
        time_next   = time_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        win_next    = win_reg;
        found_next  = found_reg;
        sel_next    = sel_reg;
        upd_next    = upd_reg;
        case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                total_next = '0;
                // a load against a full table is marked through found_reg for the report
                found_next = start && command == CMD_LOAD && count_reg == CW'(MAX_PROCESSES);
                if (start && command == CMD_LOAD && count_reg != CW'(MAX_PROCESSES))
                begin
                    sel_next    = count_reg[AW-1:0];
                    count_next  = count_reg + CW'(1);
                    active_next = active_reg + CW'(1);
                end
            end
            S_SUM_ACC:
            begin
                total_next = total_reg + sum_add;
                idx_next   = idx_reg + CW'(1);
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = '0;
                    total_next = '0;
                    win_next   = div_rem + 32'd1;
                end
            end
            S_PICK_ACC:
            begin
                total_next = total_reg + sum_add;
                if (eligible && row_valid && total_reg + sum_add >= win_reg)
                begin
                    found_next = 1'b1;
                    sel_next   = idx_reg[AW-1:0];
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_UPDATE:
            begin
                upd_next = ram_rdata;
                if (!ram_rdata.started)
                begin
                    upd_next.started = 1'b1;
                    upd_next.resp    = time_reg - {12'd0, ram_rdata.arr};
                end
                if (ram_rdata.rem != 16'd0)
                begin
                    upd_next.rem = ram_rdata.rem - 16'd1;
                end
                if (upd_next.rem == 16'd0)
                begin
                    upd_next.fin = 1'b1;
                    if (active_reg != '0)
                    begin
                        active_next = active_reg - CW'(1);
                    end
                end
                time_next = time_inc;
            end
            S_REPORT:
            begin
                if (cmd_reg == CMD_STEP && !found_reg)
                begin
                    time_next = time_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    // write-back of the selected entry is issued in the cycle after the update is formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            active_reg    <= '0;
            time_reg      <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            wb_reg        <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            time_reg      <= time_next;
            done_reg      <= (state_reg == S_REPORT);
            found_reg     <= found_next;
            wb_reg        <= (state_reg == S_UPDATE);
            // divider starts once the full ticket total is registered
            div_start_reg <= (state_reg == S_SUM_ACC) && (idx_reg + CW'(1) >= count_reg)
                             && (total_next != 32'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        total_reg <= total_next;
        win_reg   <= win_next;
        sel_reg   <= sel_next;
        upd_reg   <= upd_next;
        if (state_reg == S_IDLE && start)
        begin
            rand_reg <= random_value;
            cmd_reg  <= command;
        end
    end

    // result register, filled in the report state
    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT)
        begin
            status_reg <= ST_IDLE;
            slot_reg   <= '0;
            proc_reg   <= '0;
            chosen_reg <= '0;
            fin_reg    <= 1'b0;
            comp_reg   <= '0;
            tat_reg    <= '0;
            wait_reg   <= '0;
            resp_reg   <= '0;
            if (cmd_reg == CMD_LOAD)
            begin
                if (found_reg)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    status_reg <= ST_LOADED;
                    slot_reg   <= 4'(sel_reg);
                    proc_reg   <= proc_of(sel_reg, np_eff);
                end
            end
            if (cmd_reg == CMD_STEP && found_reg)
            begin
                status_reg <= ST_RAN;
                slot_reg   <= 4'(sel_reg);
                proc_reg   <= proc_of(sel_reg, np_eff);
                chosen_reg <= upd_reg.id;
                resp_reg   <= upd_reg.resp;
                if (upd_reg.fin)
                begin
                    fin_reg  <= 1'b1;
                    comp_reg <= time_reg;
                    tat_reg  <= time_reg - {12'd0, upd_reg.arr};
                    wait_reg <= (time_reg - {12'd0, upd_reg.arr} >= {16'd0, upd_reg.burst})
                              ? time_reg - {12'd0, upd_reg.arr} - {16'd0, upd_reg.burst}
                              : 32'd0;
                end
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign chosen_id       = chosen_reg;
    assign processor       = proc_reg;
    assign finished        = fin_reg;
    assign completion_time = comp_reg;
    assign turnaround      = tat_reg;
    assign waiting         = wait_reg;
    assign response        = resp_reg;
    assign time_now        = time_reg;
    assign all_done        = (active_reg == '0);

    `include "lottery_process_scheduler_macros.svh"

    `LPS_ASSERT_NEXT(a_done_after_report, state_reg == S_REPORT, done)
    `LPS_ASSERT_IMP(a_active_le_count, 1'b1, active_reg <= count_reg)
    `LPS_ASSERT_IMP(a_idle_when_done, done, !busy)
    `LPS_ASSERT_NEXT(a_wb_follows_update, state_reg == S_UPDATE, wb_reg)
endmodule
`default_nettype wire

@@ rtl/lps_ram.sv @@
`default_nettype none
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/lps_divider.sv @@
`default_nettype none
// restoring remainder of a 31-bit dividend by a 32-bit divisor, one bit per cycle
module lps_divider
    import lps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);
    logic [4:0]  count_reg, count_next;
    logic        run_reg, run_next;
    logic [30:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] shifted;

    always_comb
    begin
        count_next = count_reg;
        run_next   = run_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        shifted    = {rem_reg[31:0], quot_reg[30]};
        done       = 1'b0;
        if (start)
        begin
            run_next   = 1'b1;
            count_next = 5'd0;
            quot_next  = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (run_reg)
        begin
            quot_next = {quot_reg[29:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
            end
            else
            begin
                rem_next = shifted;
            end
            count_next = count_reg + 5'd1;
            if (count_reg == 5'd30)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
    end

    assign remainder = rem_next[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end
endmodule
`default_nettype wire
